/* design/encoder_velocity_pid_defines.svh */
// Assertion macros shared by the checker of the encoder velocity PID block.
`ifndef ENCODER_VELOCITY_PID_DEFINES_SVH
`define ENCODER_VELOCITY_PID_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define EVP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("encoder_velocity_pid assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define EVP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("encoder_velocity_pid assertion failed");

`endif

/* design/evp_pkg.sv */
// Types and constants shared by the encoder velocity PID modules.
package evp_pkg;

   localparam logic [28:0] TWO_PI_MS = 29'd411775000;
   localparam logic [9:0]  MS_PER_S  = 10'd1000;
   localparam logic [15:0] CPR_RESET = 16'd1024;

   typedef enum logic [2:0] {
      CSR_TARGET, CSR_GAIN_P, CSR_GAIN_I, CSR_GAIN_D, CSR_CPR
   } csr_index_type;

   typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_VEL_START, ST_VEL_WAIT, ST_INT_START, ST_INT_WAIT,
      ST_DER_START, ST_DER_WAIT, ST_MUL_LOAD, ST_MUL_RUN, ST_MUL_ACC, ST_FINISH
   } evp_state_type;

   typedef struct packed {
      logic load_in;
      logic vel_start;
      logic int_start;
      logic der_start;
      logic mul_load;
      logic mul_step;
      logic mul_acc;
      logic commit;
   } evp_cmd_type;

   typedef struct packed {
      logic zero_elapsed;
      logic div_done;
      logic mul_done;
      logic term_last;
   } evp_status_type;

endpackage

/* design/encoder_velocity_pid.sv */
// Encoder velocity PID controller: one drive transaction per accepted control tick.
// Each request transaction carries an absolute encoder count and the milliseconds since
// the previous tick; the block derives the shaft velocity in Q16.16 rad/s, runs one PID
// step against the configured target and returns an 8-bit drive duty with a clip flag.
// A tick runs from acceptance to result through two passes of the serial divider
// (velocity, derivative), a reciprocal multiplication for the integral increment,
// three shift-add passes of the gain multiplier and a finishing state. A tick with
// zero elapsed time skips to the finishing state, returns drive 0 and leaves state alone.
// The result sits in an output register, so the next request is taken while it waits.
// Configuration writes are taken at any edge with csr_write_enable high and should be
// issued only while the block is idle.
module encoder_velocity_pid
   import evp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_encoder_count,
   input  logic [15:0]        req_elapsed_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_drive,
   output logic               rsp_clipped
);
   evp_cmd_type    cmd;
   evp_status_type status;

   // The sequencer owns the handshakes; the datapath owns all arithmetic and PID state.
   evp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   evp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_encoder_count (req_encoder_count),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_drive         (rsp_drive),
      .rsp_clipped       (rsp_clipped),
      .cmd               (cmd),
      .status            (status)
   );
endmodule

/* design/evp_div.sv */
// Serial restoring divider: one quotient bit per cycle, unsigned 64 by 32.
module evp_div
   import evp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [63:0] quot
);
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         quo_in  = num;
         rem_in  = 33'd0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

/* design/evp_ctrl.sv */
// Sequencer that steps one control tick through the PID datapath.
module evp_ctrl
   import evp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  evp_status_type status,
   output evp_cmd_type    cmd
);
   evp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_VEL_START;
         ST_VEL_START: state_in = status.zero_elapsed ? ST_FINISH : ST_VEL_WAIT;
         ST_VEL_WAIT:  if (status.div_done) state_in = ST_INT_START;
         ST_INT_START: state_in = ST_INT_WAIT;
         ST_INT_WAIT:  if (status.div_done) state_in = ST_DER_START;
         ST_DER_START: state_in = ST_DER_WAIT;
         ST_DER_WAIT:  if (status.div_done) state_in = ST_MUL_LOAD;
         ST_MUL_LOAD:  state_in = ST_MUL_RUN;
         ST_MUL_RUN:   if (status.mul_done) state_in = ST_MUL_ACC;
         ST_MUL_ACC:   state_in = status.term_last ? ST_FINISH : ST_MUL_LOAD;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      cmd.load_in   = (state_ff == ST_IDLE) && req_valid;
      cmd.vel_start = (state_ff == ST_VEL_START) && !status.zero_elapsed;
      cmd.int_start = (state_ff == ST_INT_START);
      cmd.der_start = (state_ff == ST_DER_START);
      cmd.mul_load  = (state_ff == ST_MUL_LOAD);
      cmd.mul_step  = (state_ff == ST_MUL_RUN);
      cmd.mul_acc   = (state_ff == ST_MUL_ACC);
      cmd.commit    = (state_ff == ST_FINISH) && out_free;
      req_ready     = (state_ff == ST_IDLE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* design/evp_dp.sv */
// Datapath: registers, PID state, serial divider, reciprocal scaling and gain multiplier.
module evp_dp
   import evp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_write_data,
   input  logic signed [31:0]    req_encoder_count,
   input  logic [15:0]           req_elapsed_ms,
   output logic [7:0]            rsp_drive,
   output logic                  rsp_clipped,
   input  evp_cmd_type           cmd,
   output evp_status_type        status
);
   localparam logic signed [63:0] TERM_MAX = 64'sd1 <<< 56;
   localparam logic signed [63:0] TERM_MIN = -(64'sd1 <<< 56);
   // ceil(2^57 / 1000): exact floor division by 1000 for numerators below 2^47.
   localparam logic [47:0]        RECIP_1000 = 48'd144115188075856;

   // Configuration registers.
   logic signed [23:0] target_ff;
   logic [15:0]        gain_p_ff, gain_i_ff, gain_d_ff, cpr_ff;

   // Persistent state and per-tick working registers.
   logic signed [31:0] last_count_ff, prev_error_ff, count_ff, velocity_ff, error_ff;
   logic signed [47:0] integral_ff, integ_new_ff;
   logic signed [43:0] deriv_ff;
   logic [15:0]        elapsed_ff;
   logic               neg_ff;
   logic [1:0]         mode_ff;
   logic signed [63:0] mcand_ff, acc_ff;
   logic [15:0]        gain_sr_ff;
   logic [3:0]         mul_cnt_ff;
   logic [1:0]         term_ff;
   logic signed [59:0] sum_ff;
   logic [7:0]         drive_ff;
   logic               clipped_ff;

   // Integral increment: error times elapsed time, scaled by 1/1000 through a
   // reciprocal multiplication that takes one 16-bit digit per cycle.
   logic [47:0]        int_num_ff;
   logic [95:0]        int_prod_ff;
   logic [1:0]         int_dig_ff;
   logic               int_busy_ff, int_done_ff;
   logic [15:0]        recip_digit;
   logic [38:0]        int_quot;

   // Divider interface.
   logic        div_start, div_done;
   logic [63:0] div_num, div_quot;
   logic [31:0] div_den;
   logic        neg_in;

   logic signed [31:0] delta, err_clamp;
   logic [31:0]        delta_mag, err_mag;
   logic [15:0]        cpr_eff;
   logic signed [32:0] err_wide, diff;
   logic [32:0]        diff_mag;
   logic signed [63:0] vel_q;
   logic signed [49:0] integ_sum;
   logic signed [63:0] term;
   logic [15:0]        gain_sel;
   logic signed [63:0] mcand_sel;

   assign cpr_eff   = (cpr_ff == 16'd0) ? 16'd1 : cpr_ff;
   assign delta     = count_ff - last_count_ff;
   assign delta_mag = delta[31] ? 32'(-delta) : 32'(delta);
   assign err_wide  = 33'(signed'({target_ff, 8'd0})) - 33'(velocity_ff);
   assign err_clamp = (err_wide > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (err_wide < -33'sh0_8000_0000) ? 32'sh8000_0000 : err_wide[31:0];
   assign err_mag   = err_clamp[31] ? 32'(-err_clamp) : 32'(err_clamp);
   assign diff      = 33'(error_ff) - 33'(prev_error_ff);
   assign diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
   assign int_quot  = int_prod_ff[95:57];

   always_comb begin
      div_start = cmd.vel_start || cmd.der_start;
      div_num   = 64'd0;
      div_den   = 32'd1;
      neg_in    = neg_ff;
      if (cmd.vel_start) begin
         div_num = 64'(delta_mag) * 64'(TWO_PI_MS);
         div_den = 32'(cpr_eff) * 32'(elapsed_ff);
         neg_in  = delta[31];
      end else if (cmd.int_start) begin
         neg_in  = err_clamp[31];
      end else if (cmd.der_start) begin
         div_num = 64'(43'(diff_mag) * 43'(MS_PER_S));
         div_den = 32'(elapsed_ff);
         neg_in  = diff[32];
      end
   end

   always_comb begin
      case (int_dig_ff)
         2'd0:    recip_digit = RECIP_1000[47:32];
         2'd1:    recip_digit = RECIP_1000[31:16];
         default: recip_digit = RECIP_1000[15:0];
      endcase
   end

   evp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Signed, saturated velocity, signed integral sum, term operand selection and clamped term.
   always_comb begin
      if (!neg_ff) begin
         vel_q = (div_quot > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : signed'(div_quot);
      end else begin
         vel_q = (div_quot > 64'h8000_0000) ? -64'sh8000_0000 : -signed'(div_quot);
      end
      integ_sum = 50'(integral_ff) +
                  (neg_ff ? -50'(signed'({1'b0, int_quot}))
                          :  50'(signed'({1'b0, int_quot})));
      case (term_ff)
         TERM_P:  begin gain_sel = gain_p_ff; mcand_sel = 64'(error_ff); end
         TERM_I:  begin gain_sel = gain_i_ff; mcand_sel = 64'(integ_new_ff); end
         default: begin gain_sel = gain_d_ff; mcand_sel = 64'(deriv_ff); end
      endcase
      term = (acc_ff > TERM_MAX) ? TERM_MAX : (acc_ff < TERM_MIN) ? TERM_MIN : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         cpr_ff        <= CPR_RESET;
         last_count_ff <= '0;
         integral_ff   <= '0;
         prev_error_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TARGET: target_ff <= signed'(csr_write_data);
               CSR_GAIN_P: gain_p_ff <= csr_write_data[15:0];
               CSR_GAIN_I: gain_i_ff <= csr_write_data[15:0];
               CSR_GAIN_D: gain_d_ff <= csr_write_data[15:0];
               CSR_CPR:    cpr_ff    <= csr_write_data[15:0];
               default: ;
            endcase
         end
         if (cmd.commit && (elapsed_ff != 16'd0)) begin
            last_count_ff <= count_ff;
            integral_ff   <= integ_new_ff;
            prev_error_ff <= error_ff;
         end
      end
   end

   // Digit sequencing of the reciprocal multiplication: three steps, then one done cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         int_busy_ff <= 1'b0;
         int_done_ff <= 1'b0;
         int_dig_ff  <= '0;
      end else begin
         int_done_ff <= int_busy_ff && !cmd.int_start && (int_dig_ff == 2'd2);
         if (cmd.int_start) begin
            int_busy_ff <= 1'b1;
            int_dig_ff  <= '0;
         end else if (int_busy_ff) begin
            int_dig_ff <= int_dig_ff + 2'd1;
            if (int_dig_ff == 2'd2) int_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         count_ff   <= req_encoder_count;
         elapsed_ff <= req_elapsed_ms;
         term_ff    <= TERM_P;
         sum_ff     <= '0;
      end
      if (div_start || cmd.int_start) neg_ff <= neg_in;
      if (div_start) mode_ff <= cmd.vel_start ? 2'd0 : 2'd2;
      if (cmd.int_start) begin
         error_ff    <= err_clamp;
         int_num_ff  <= 48'(err_mag) * 48'(elapsed_ff);
         int_prod_ff <= '0;
      end else if (int_busy_ff) begin
         int_prod_ff <= {int_prod_ff[79:0], 16'd0} + 96'(64'(int_num_ff) * 64'(recip_digit));
      end
      if (div_done) begin
         case (mode_ff)
            2'd0:    velocity_ff <= vel_q[31:0];
            default: deriv_ff <= neg_ff ? -signed'({1'b0, div_quot[42:0]})
                                        :  signed'({1'b0, div_quot[42:0]});
         endcase
      end
      if (int_done_ff) begin
         integ_new_ff <= (integ_sum > 50'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                         (integ_sum < -50'sh0_8000_0000_0000) ?
                         48'sh8000_0000_0000 : integ_sum[47:0];
      end
      if (cmd.mul_load) begin
         mcand_ff   <= mcand_sel;
         gain_sr_ff <= gain_sel;
         acc_ff     <= '0;
         mul_cnt_ff <= '0;
      end else if (cmd.mul_step) begin
         if (gain_sr_ff[0]) acc_ff <= acc_ff + mcand_ff;
         mcand_ff   <= mcand_ff <<< 1;
         gain_sr_ff <= gain_sr_ff >> 1;
         mul_cnt_ff <= mul_cnt_ff + 4'd1;
      end
      if (cmd.mul_acc) begin
         sum_ff  <= sum_ff + 60'(term);
         term_ff <= term_ff + 2'd1;
      end
      if (cmd.commit) begin
         if (elapsed_ff == 16'd0) begin
            drive_ff   <= 8'd0;
            clipped_ff <= 1'b0;
         end else if (sum_ff < 60'sd0) begin
            drive_ff   <= 8'd0;
            clipped_ff <= (sum_ff <= -(60'sd1 <<< 24));
         end else if (sum_ff >= (60'sd1 <<< 32)) begin
            drive_ff   <= 8'hFF;
            clipped_ff <= 1'b1;
         end else begin
            drive_ff   <= sum_ff[31:24];
            clipped_ff <= 1'b0;
         end
      end
   end

   // Either the divider or the integral scaling reports completion to the sequencer.
   assign status.zero_elapsed = (elapsed_ff == 16'd0);
   assign status.div_done     = div_done || int_done_ff;
   assign status.mul_done     = (mul_cnt_ff == 4'd15);
   assign status.term_last    = (term_ff == TERM_D);
   assign rsp_drive           = drive_ff;
   assign rsp_clipped         = clipped_ff;
endmodule

/* design/evp_checker.sv */
// Port-level checker for the encoder velocity PID block and its bind.
`include "encoder_velocity_pid_defines.svh"
module evp_port_checker
   import evp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_drive,
   input logic        rsp_clipped
);
   `EVP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `EVP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable({rsp_drive, rsp_clipped}))
   `EVP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `EVP_ASSERT_NOW(a_clip_rails, rsp_valid && rsp_clipped, (rsp_drive == 8'd0) || (rsp_drive == 8'hFF))
endmodule

bind encoder_velocity_pid evp_port_checker u_evp_port_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_drive   (rsp_drive),
   .rsp_clipped (rsp_clipped)
);

/* dv/evp_checker.sv */
// Checker for the encoder velocity PID block: predicts each drive transaction and compares.
module evp_checker
   import evp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_write_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_encoder_count,
   input  logic [15:0]        req_elapsed_ms,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_drive,
   input  logic               rsp_clipped,
   output int                 fail_count,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TWO_PI_Q16_MS = 64'sd411775000;
   localparam longint MS_IN_S       = 64'sd1000;
   localparam longint S32_LO        = -(64'sd1 <<< 31);
   localparam longint S32_HI        = (64'sd1 <<< 31) - 1;
   localparam longint S48_LO        = -(64'sd1 <<< 47);
   localparam longint S48_HI        = (64'sd1 <<< 47) - 1;
   localparam longint PRODUCT_LIM   = 64'sd1 <<< 56;
   localparam longint OUT_SCALE     = 64'sd1 <<< 24;

   typedef struct {
      logic [7:0] drive;
      logic       clipped;
   } drive_result_type;

   drive_result_type   drive_queue[$];

   logic signed [23:0] target_vel;
   logic [15:0]        kp, ki, kd, cpr;
   logic [31:0]        prev_count;
   longint             err_integral, prev_err;
   int                 mismatches;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Runs one control tick on the shadow state and returns the expected drive.
   function automatic drive_result_type pid_tick(logic [31:0] count, logic [15:0] ms);
      drive_result_type res;
      logic [31:0]      diff;
      longint           delta, vel, err, deriv, p, i, d, value, ms_l, cpr_l;
      res.drive   = '0;
      res.clipped = 1'b0;
      if (ms == 16'd0) return res;
      ms_l  = longint'(ms);
      cpr_l = (cpr == 16'd0) ? 64'sd1 : longint'(cpr);
      diff  = count - prev_count;
      delta = longint'($signed(diff));
      vel   = clamp((delta * TWO_PI_Q16_MS) / (cpr_l * ms_l), S32_LO, S32_HI);
      err   = clamp(longint'(target_vel) * 256 - vel, S32_LO, S32_HI);
      err_integral = clamp(err_integral + (err * ms_l) / MS_IN_S, S48_LO, S48_HI);
      deriv = ((err - prev_err) * MS_IN_S) / ms_l;
      p = clamp(longint'(kp) * err, -PRODUCT_LIM, PRODUCT_LIM);
      i = clamp(longint'(ki) * err_integral, -PRODUCT_LIM, PRODUCT_LIM);
      d = clamp(longint'(kd) * deriv, -PRODUCT_LIM, PRODUCT_LIM);
      value = (p + i + d) / OUT_SCALE;
      if (value < 0) begin
         res.clipped = 1'b1;
      end else if (value > 255) begin
         res.drive   = 8'hFF;
         res.clipped = 1'b1;
      end else begin
         res.drive = value[7:0];
      end
      prev_count = count;
      prev_err   = err;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] drive check: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         target_vel   = '0;
         kp           = '0;
         ki           = '0;
         kd           = '0;
         cpr          = CPR_RESET;
         prev_count   = '0;
         err_integral = 0;
         prev_err     = 0;
         mismatches   = 0;
         drive_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TARGET: target_vel = csr_write_data;
               CSR_GAIN_P: kp = csr_write_data[15:0];
               CSR_GAIN_I: ki = csr_write_data[15:0];
               CSR_GAIN_D: kd = csr_write_data[15:0];
               CSR_CPR:    cpr = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_queue.size() == 0) begin
               report_mismatch("unexpected transaction, drive", rsp_drive, -1);
            end else begin
               want = drive_queue.pop_front();
               if (rsp_drive !== want.drive) report_mismatch("drive", rsp_drive, want.drive);
               if (rsp_clipped !== want.clipped)
                  report_mismatch("clipped", rsp_clipped, want.clipped);
            end
         end
         if (req_valid && req_ready)
            drive_queue.push_back(pid_tick(req_encoder_count, req_elapsed_ms));
      end
      outstanding <= drive_queue.size();
      fail_count  <= mismatches;
   end

endmodule

/* dv/tb_top.sv */
// Testbench top for the encoder velocity PID block: stimulus, handshake pacing and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import evp_pkg::*;

   // Index past the end of the register list; the block must ignore writes to it.
   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam int         SETTLE     = 300;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         LONG_HOLD  = 1500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_encoder_count = '0;
   logic [15:0]        req_elapsed_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_drive;
   logic               rsp_clipped;
   int                 fail_count;
   int                 outstanding;

   // Stimulus state: the last count offered, how much of the current burst is left,
   // whether gaps are allowed, and a request for the receiver to hold off.
   logic signed [31:0] sent_count = '0;
   int                 burst_left = 0;
   bit                 gaps_on = 1'b1;
   bit                 hold_long = 1'b0;
   int                 idle_cycles = 0;
   logic signed [31:0] count_val;
   logic [15:0]        ms_val;

   encoder_velocity_pid u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_encoder_count (req_encoder_count),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_clipped       (rsp_clipped)
   );

   evp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_encoder_count (req_encoder_count),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_clipped       (rsp_clipped),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // The receiver switches between always ready, mostly ready and mostly stalled, each
   // kept for a random stretch. On request it holds off for a long stretch so that the
   // output register fills and the block stops taking new ticks.
   initial begin
      int mode;
      int stretch;
      mode    = 0;
      stretch = 0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end
         if (stretch == 0) begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 400);
         end
         stretch--;
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: the run is stuck if no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one control tick and returns once it is accepted. Between bursts, when gaps
   // are allowed, the valid line drops for a random gap.
   task automatic send_tick(input logic signed [31:0] count, input logic [15:0] ms);
      req_valid         <= 1'b1;
      req_encoder_count <= count;
      req_elapsed_ms    <= ms;
      do @(posedge clock); while (!req_ready);
      sent_count = count;
      if (burst_left > 0) begin
         burst_left--;
      end else if (gaps_on) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end else begin
         burst_left = $urandom_range(5, 30);
      end
   endtask

   // Waits until every expected drive transaction has come back and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed motion: a small step from the last count over a short tick.
   // The rest is zero elapsed time and fully random counts and times.
   task automatic random_tick();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         count_val = sent_count + ($signed($urandom_range(0, 4000)) - 2000);
         ms_val    = 16'($urandom_range(1, 20));
      end else if (pick < 88) begin
         count_val = $urandom;
         ms_val    = '0;
      end else begin
         count_val = $urandom;
         ms_val    = 16'($urandom);
      end
      send_tick(count_val, ms_val);
   endtask

   task automatic random_gain(input logic [2:0] idx);
      case ($urandom_range(0, 3))
         0:       write_reg(idx, 24'd0);
         1:       write_reg(idx, 24'hFFFF);
         2:       write_reg(idx, 24'($urandom_range(1, 512)));
         default: write_reg(idx, 24'($urandom));
      endcase
   endtask

   task automatic random_config();
      case ($urandom_range(0, 3))
         0:       write_reg(CSR_TARGET, 24'h7FFFFF);
         1:       write_reg(CSR_TARGET, 24'h800000);
         2:       write_reg(CSR_TARGET, 24'($urandom));
         default: write_reg(CSR_TARGET, 24'($urandom_range(0, 4096)));
      endcase
      random_gain(CSR_GAIN_P);
      random_gain(CSR_GAIN_I);
      random_gain(CSR_GAIN_D);
      case ($urandom_range(0, 3))
         0:       write_reg(CSR_CPR, 24'd0);
         1:       write_reg(CSR_CPR, 24'd1);
         2:       write_reg(CSR_CPR, 24'hFFFF);
         default: write_reg(CSR_CPR, 24'($urandom_range(16, 4096)));
      endcase
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First a tick under reset settings, then moderate gains.
      send_tick(32'sd50, 16'd1);
      drain();
      write_reg(CSR_TARGET, 24'd768);
      write_reg(CSR_GAIN_P, 24'd256);
      write_reg(CSR_GAIN_I, 24'd64);
      write_reg(CSR_GAIN_D, 24'd4);
      write_reg(CSR_CPR, 24'd1024);
      send_tick(32'sd0, 16'd0);              // zero elapsed time: no state change
      send_tick(32'sd100, 16'd1);
      send_tick(32'sd100, 16'd65535);
      send_tick(32'sh7FFFFFFF, 16'd1);
      send_tick(32'sh80000000, 16'd1);       // count wraps across the sign boundary
      send_tick(32'sh80000000, 16'd65535);
      send_tick(32'sh7FFFFFFF, 16'd0);
      send_tick(32'sd0, 16'd10);
      drain();
      write_reg(CSR_CPR, 24'd0);             // zero counts per revolution acts as one
      write_reg(CSR_UNUSED, 24'hFFFFFF);     // write past the register list is ignored
      send_tick(32'sd5000, 16'd3);
      send_tick(-32'sd5000, 16'd3);
      drain();
      write_reg(CSR_CPR, 24'hFFFF);
      write_reg(CSR_GAIN_P, 24'hFFFF);
      write_reg(CSR_GAIN_I, 24'hFFFF);
      write_reg(CSR_GAIN_D, 24'hFFFF);
      write_reg(CSR_TARGET, 24'h7FFFFF);
      send_tick(32'sd7, 16'd2);
      send_tick(32'sd7, 16'd2);
      drain();
      write_reg(CSR_TARGET, 24'h800000);
      send_tick(32'sd9, 16'd1);
      send_tick(32'sd9, 16'd1);
      drain();

      // Random part: several phases, each with its own settings.
      for (int phase = 0; phase < 7; phase++) begin
         random_config();
         gaps_on = (phase != 2);
         for (int n = 0; n < 190; n++) begin
            if (phase == 1 && n == 40) hold_long = 1'b1;
            if (phase == 3 && n == 60) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (outstanding != 0) @(posedge clock);
            end
            random_tick();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/evp_pkg.sv
design/evp_div.sv
design/evp_ctrl.sv
design/evp_dp.sv
design/encoder_velocity_pid.sv
design/evp_checker.sv
dv/evp_checker.sv
dv/tb_top.sv
